FILE: hdl/irclt_pkg.sv
// ----------------------------------------------------------------------------
// irclt_pkg
// Types, codes and the per-byte field classifier shared by the IRC line
// tokenizer modules.
// ----------------------------------------------------------------------------
package irclt_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [12:0] LEN_SAT = 13'h1fff;

  localparam logic [1:0] REG_MAX_PARAMS      = 2'd0;
  localparam logic [1:0] REG_MAX_LINE_LENGTH = 2'd1;

  localparam logic [1:0] KIND_PREFIX   = 2'd0;
  localparam logic [1:0] KIND_COMMAND  = 2'd1;
  localparam logic [1:0] KIND_MIDDLE   = 2'd2;
  localparam logic [1:0] KIND_TRAILING = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_PARAMS = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_CMD_SEP,
    PH_COMMAND,
    PH_PARAM_SEP,
    PH_MIDDLE,
    PH_TRAILING,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_BYTE,
    EV_END
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  param_count;
    logic        field_open;
    logic [1:0]  error_flags;
  } tok_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
  } tag_t;

  typedef struct packed {
    tok_state_t st;
    event_t     ev;
    tag_t       tag;
  } take_t;

  typedef struct packed {
    logic [3:0]  max_params;
    logic [13:0] limit_m2;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       held_cr;
    logic       byte_valid;
    logic [1:0] field_kind;
    logic [3:0] param_index;
    logic       field_end;
    logic       line_end;
    logic [1:0] status;
  } result_t;

  function automatic tag_t tag_of(phase_t ph, logic [3:0] count);
    tag_t t;
    t.kind = KIND_PREFIX;
    t.idx  = 4'd0;
    unique case (ph)
      PH_COMMAND:  t.kind = KIND_COMMAND;
      PH_MIDDLE: begin
        t.kind = KIND_MIDDLE;
        t.idx  = count - 4'd1;
      end
      PH_TRAILING: begin
        t.kind = KIND_TRAILING;
        t.idx  = count - 4'd1;
      end
      PH_START, PH_PREFIX, PH_CMD_SEP, PH_PARAM_SEP, PH_DISCARD: t.kind = KIND_PREFIX;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] status_of(logic [1:0] flags);
    logic [1:0] s;
    if (flags[1]) s = STATUS_LENGTH;
    else if (flags[0]) s = STATUS_PARAMS;
    else s = STATUS_OK;
    return s;
  endfunction

  // Classify one non-framing byte that lies within the length limit.
  function automatic take_t take_byte(tok_state_t s, logic [7:0] b, logic [3:0] mp);
    take_t      r;
    logic       sp;
    logic       colon;
    logic [3:0] mpe;
    r.st  = s;
    r.ev  = EV_NONE;
    r.tag = '0;
    sp    = (b == CHAR_SPACE);
    colon = (b == CHAR_COLON);
    mpe   = (mp == 4'd0) ? 4'd1 : mp;
    unique case (s.phase)
      PH_START: begin
        if (colon) begin
          r.st.phase      = PH_PREFIX;
          r.st.field_open = 1'b1;
        end else if (sp) begin
          r.st.phase = PH_CMD_SEP;
        end else begin
          r.st.phase      = PH_COMMAND;
          r.st.field_open = 1'b1;
          r.ev            = EV_BYTE;
          r.tag           = tag_of(PH_COMMAND, s.param_count);
        end
      end
      PH_CMD_SEP: begin
        if (!sp) begin
          r.st.phase      = PH_COMMAND;
          r.st.field_open = 1'b1;
          r.ev            = EV_BYTE;
          r.tag           = tag_of(PH_COMMAND, s.param_count);
        end
      end
      PH_PREFIX, PH_COMMAND, PH_MIDDLE: begin
        r.tag = tag_of(s.phase, s.param_count);
        if (sp) begin
          r.st.phase      = (s.phase == PH_PREFIX) ? PH_CMD_SEP : PH_PARAM_SEP;
          r.st.field_open = 1'b0;
          r.ev            = EV_END;
        end else begin
          r.ev = EV_BYTE;
        end
      end
      PH_PARAM_SEP: begin
        if (!sp) begin
          if (s.param_count >= mpe) begin
            r.st.error_flags = s.error_flags | 2'b01;
            r.st.phase       = PH_DISCARD;
            r.st.field_open  = 1'b0;
          end else begin
            r.st.param_count = s.param_count + 4'd1;
            r.st.phase       = colon ? PH_TRAILING : PH_MIDDLE;
            r.st.field_open  = 1'b1;
            if (!colon) begin
              r.ev  = EV_BYTE;
              r.tag = tag_of(PH_MIDDLE, r.st.param_count);
            end
          end
        end
      end
      PH_TRAILING: begin
        r.ev  = EV_BYTE;
        r.tag = tag_of(PH_TRAILING, s.param_count);
      end
      PH_DISCARD: r.ev = EV_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/irclt_cfg.sv
// ----------------------------------------------------------------------------
// irclt_cfg
// Configuration registers; stores the line limit already clamped, minus two.
// ----------------------------------------------------------------------------
module irclt_cfg import irclt_pkg::*; #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [12:0] wr_data,
  output cfg_t        cfg
);

  localparam logic [13:0] MaxLine = 14'(MAX_LINE);
  localparam logic [13:0] MinLine = 14'd16;

  function automatic logic [13:0] limit_m2_of(logic [12:0] v);
    logic [13:0] l;
    l = {1'b0, v};
    if (l > MaxLine) l = MaxLine;
    if (l < MinLine) l = MinLine;
    return l - 14'd2;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_params <= 4'd15;
      cfg.limit_m2   <= limit_m2_of(13'd512);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_PARAMS:      cfg.max_params <= wr_data[3:0];
        REG_MAX_LINE_LENGTH: cfg.limit_m2   <= limit_m2_of(wr_data);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/irclt_core.sv
// ----------------------------------------------------------------------------
// irclt_core
// Line state registers and the single-pass byte classifier.
// ----------------------------------------------------------------------------
module irclt_core import irclt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  tok_state_t  st;
  tok_state_t  st_next;
  logic        cr_pending;
  logic        cr_pending_next;
  logic [12:0] line_length;
  logic [12:0] line_length_next;

  take_t       t1;
  take_t       t2;
  tok_state_t  s1;
  logic        hc;
  logic        bv;
  logic        fe;

  always_comb begin
    st_next          = st;
    cr_pending_next  = cr_pending;
    line_length_next = line_length;
    res              = '0;
    res_valid        = 1'b0;
    t1               = '0;
    t2               = '0;
    s1               = st;
    hc               = 1'b0;
    bv               = 1'b0;
    fe               = 1'b0;
    if (cr_pending && data_byte == CHAR_LF) begin
      res.line_end = 1'b1;
      if (st.field_open) begin
        res.field_end = 1'b1;
        {res.field_kind, res.param_index} = tag_of(st.phase, st.param_count);
      end
      res.status       = status_of(st.error_flags);
      res_valid        = 1'b1;
      st_next          = '{phase: PH_START, param_count: 4'd0, field_open: 1'b0,
                           error_flags: 2'b00};
      cr_pending_next  = 1'b0;
      line_length_next = 13'd0;
    end else begin
      if (cr_pending) begin
        if ({1'b0, line_length} > cfg.limit_m2) begin
          s1.error_flags = st.error_flags | 2'b10;
        end else begin
          t1 = take_byte(st, CHAR_CR, cfg.max_params);
          s1 = t1.st;
          hc = (t1.ev == EV_BYTE);
        end
      end
      line_length_next = (line_length == LEN_SAT) ? line_length : line_length + 13'd1;
      cr_pending_next  = (data_byte == CHAR_CR);
      st_next          = s1;
      if (data_byte != CHAR_CR) begin
        if ({1'b0, line_length_next} > cfg.limit_m2) begin
          st_next.error_flags = s1.error_flags | 2'b10;
        end else begin
          t2      = take_byte(s1, data_byte, cfg.max_params);
          st_next = t2.st;
          bv      = (t2.ev == EV_BYTE);
          fe      = (t2.ev == EV_END);
        end
      end
      res.out_byte   = bv ? data_byte : 8'd0;
      res.held_cr    = hc;
      res.byte_valid = bv;
      res.field_end  = fe;
      if (bv || fe) begin
        {res.field_kind, res.param_index} = t2.tag;
      end else if (hc) begin
        {res.field_kind, res.param_index} = t1.tag;
      end
      res.status = status_of(st_next.error_flags);
      res_valid  = hc || bv || fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{phase: PH_START, param_count: 4'd0, field_open: 1'b0,
                       error_flags: 2'b00};
      cr_pending  <= 1'b0;
      line_length <= 13'd0;
    end else if (fire) begin
      st          <= st_next;
      cr_pending  <= cr_pending_next;
      line_length <= line_length_next;
    end
  end

endmodule

FILE: hdl/irc_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// irc_line_tokenizer_unit
// Frames an IRC byte stream on CR LF and tags each content byte with its
// field kind and parameter index.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle as long as the consumer does not stall.
// A byte is held in the input register, is classified in one pass and lands
// in the result register once the output is free. Bytes that produce no
// result (spaces between fields, held CR, dropped bytes) leave the result
// register untouched and clear out_valid. Configuration writes are
// registered; cfg_ready is always high.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_unit import irclt_pkg::*; #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        held_cr,
  output logic        byte_valid,
  output logic [1:0]  field_kind,
  output logic [3:0]  param_index,
  output logic        field_end,
  output logic        line_end,
  output logic [1:0]  status
);

  cfg_t       cfg;
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    out_reg;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign accept    = in_valid && !in_stall;

  irclt_cfg #(
    .MAX_LINE (MAX_LINE)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irclt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
    end
    if (advance && res_valid) begin
      out_reg <= res;
    end
  end

  assign out_byte    = out_reg.out_byte;
  assign held_cr     = out_reg.held_cr;
  assign byte_valid  = out_reg.byte_valid;
  assign field_kind  = out_reg.field_kind;
  assign param_index = out_reg.param_index;
  assign field_end   = out_reg.field_end;
  assign line_end    = out_reg.line_end;
  assign status      = out_reg.status;

endmodule
